[rtl/core/cma35_pkg.sv]
package cma35_pkg;

  localparam int WIN_DEPTH = 5;

  // Job codes double as the window slot of the bin being smoothed.
  localparam logic [1:0] JOB_END  = 2'd0;
  localparam logic [1:0] JOB_MID  = 2'd1;
  localparam logic [1:0] JOB_NORM = 2'd2;

  typedef struct packed {
    logic                 shift;
    logic                 load_sums;
    logic                 div_start;
    logic                 div_sel5;
    logic                 cap3;
    logic                 cap5;
    logic                 push;
    logic                 push_end;
    logic [WIN_DEPTH-1:0] mask3;
    logic [WIN_DEPTH-1:0] mask5;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  // Slots present in the window and within reach of the centre slot.
  function automatic logic [WIN_DEPTH-1:0] tap_mask(input logic [1:0] ctr,
                                                    input logic [2:0] n,
                                                    input logic [1:0] reach);
    logic [WIN_DEPTH-1:0] m;
    m = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      m[i] = (3'(i) < n) && (4'(i) <= 4'(ctr) + 4'(reach)) &&
             (4'(i) + 4'(reach) >= 4'(ctr));
    end
    return m;
  endfunction

  function automatic logic [2:0] count_taps(input logic [WIN_DEPTH-1:0] mask);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      c = c + 3'(mask[i]);
    end
    return c;
  endfunction

endpackage

[rtl/core/centered_moving_average_3_5.sv]
// Smooths a histogram streamed one bin count per beat, giving for each bin the
// centred mean over 3 bins (rounded half up) and over 5 bins (rounded half down),
// with the windows cut short at both ends of the histogram. The result for bin i
// leaves once bin i+2 has arrived; the beat with tlast set also flushes the last
// two bins, so it may produce up to three results, and the block is then ready
// for a new histogram. Both means share one restoring divider, SW+4 bits wide,
// SW being SAMPLE_BITS capped at 16, that retires one quotient bit a cycle. A
// new bin is taken only once all results of the previous one are computed; a
// finished result may still be waiting in the output register. bin_index
// counts from 0 and wraps after MAX_BINS-1.
module centered_moving_average_3_5 #(
  parameter int MAX_BINS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // bin_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // bin_index, smooth_three, smooth_five
  output logic        m_axis_tlast
);
  import cma35_pkg::*;

  localparam int SW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int PW = $clog2(MAX_BINS);

  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  bin_index;
  logic [15:0] smooth_three;
  logic [15:0] smooth_five;

  cma35_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_last  (s_axis_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  cma35_dp #(
    .SW       (SW),
    .PW       (PW),
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample_in (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (bin_index),
    .out_three (smooth_three),
    .out_five  (smooth_five),
    .out_end   (m_axis_tlast)
  );

  assign m_axis_tdata = {smooth_five, smooth_three, bin_index};

endmodule

[rtl/core/cma35_div.sv]
module cma35_div #(
  parameter int NW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [3:0]    den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] qr;
  logic [3:0]    rem;
  logic [3:0]    den_q;
  logic [4:0]    trial;
  logic [4:0]    diff;
  logic          ge;

  always_comb begin
    trial = {rem, qr[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr    <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (ge) begin
        rem <= diff[3:0];
        qr  <= {qr[NW-2:0], 1'b1};
      end else begin
        rem <= trial[3:0];
        qr  <= {qr[NW-2:0], 1'b0};
      end
    end
  end

  assign quot = qr;

endmodule

[rtl/core/cma35_dp.sv]
module cma35_dp #(
  parameter int SW = 16,
  parameter int PW = 8,
  parameter int MAX_BINS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  cma35_pkg::cmd_t   cmd,
  output cma35_pkg::sts_t   sts,
  input  logic [15:0]       sample_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_index,
  output logic [15:0]       out_three,
  output logic [15:0]       out_five,
  output logic              out_end
);
  import cma35_pkg::*;

  localparam int NW = SW + 4;

  logic [SW-1:0]   win [WIN_DEPTH];
  logic [SW+1:0]   s3;
  logic [SW+2:0]   s5;
  logic [SW+1:0]   s3_sum;
  logic [SW+2:0]   s5_sum;
  logic [2:0]      c3;
  logic [2:0]      c5;
  logic [SW-1:0]   mean3;
  logic [SW-1:0]   mean5;
  logic [PW-1:0]   pos;
  logic [NW-1:0]   num3;
  logic [NW-1:0]   num5;
  logic [NW-1:0]   div_num;
  logic [3:0]      div_den;
  logic            div_done;
  logic [NW-1:0]   div_quot;

  always_comb begin
    s3_sum = '0;
    s5_sum = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (cmd.mask3[i]) s3_sum = s3_sum + (SW+2)'(win[i]);
      if (cmd.mask5[i]) s5_sum = s5_sum + (SW+3)'(win[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win[0] <= sample_in[SW-1:0];
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win[i] <= win[i-1];
      end
    end
    if (cmd.load_sums) begin
      s3 <= s3_sum;
      s5 <= s5_sum;
      c3 <= count_taps(cmd.mask3);
      c5 <= count_taps(cmd.mask5);
    end
    if (cmd.cap3) mean3 <= div_quot[SW-1:0];
    if (cmd.cap5) mean5 <= div_quot[SW-1:0];
  end

  // Half up: (2s+c)/2c. Half down: (2s+c-1)/2c.
  assign num3    = NW'({s3, 1'b0}) + NW'(c3);
  assign num5    = NW'({s5, 1'b0}) + NW'(c5) - NW'(1);
  assign div_num = cmd.div_sel5 ? num5 : num3;
  assign div_den = cmd.div_sel5 ? {c5, 1'b0} : {c3, 1'b0};

  cma35_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (cmd.push) begin
        out_valid <= 1'b1;
        if (cmd.push_end || pos == PW'(MAX_BINS - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + PW'(1);
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_index <= 8'(pos);
      out_three <= 16'(mean3);
      out_five  <= 16'(mean5);
      out_end   <= cmd.push_end;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

[rtl/core/cma35_ctrl.sv]
module cma35_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_last,
  input  cma35_pkg::sts_t sts,
  output cma35_pkg::cmd_t cmd
);
  import cma35_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLAN  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DIV3  = 3'd3;
  localparam logic [2:0] S_WAIT3 = 3'd4;
  localparam logic [2:0] S_DIV5  = 3'd5;
  localparam logic [2:0] S_WAIT5 = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] bins_seen;
  logic [2:0] bins_seen_next;
  logic       fin;
  logic       fin_next;
  logic [1:0] job;
  logic [1:0] job_next;

  always_comb begin
    state_next     = state;
    bins_seen_next = bins_seen;
    fin_next       = fin;
    job_next       = job;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mask3      = tap_mask(job, bins_seen, 2'd1);
    cmd.mask5      = tap_mask(job, bins_seen, 2'd2);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift      = 1'b1;
          fin_next       = in_last;
          bins_seen_next = (bins_seen == 3'(WIN_DEPTH)) ? bins_seen : bins_seen + 3'd1;
          state_next     = S_PLAN;
        end
      end
      S_PLAN: begin
        if (bins_seen >= 3'd3) begin
          job_next   = JOB_NORM;
          state_next = S_SUM;
        end else if (fin) begin
          job_next   = (bins_seen >= 3'd2) ? JOB_MID : JOB_END;
          state_next = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.load_sums = 1'b1;
        state_next    = S_DIV3;
      end
      S_DIV3: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT3;
      end
      S_WAIT3: begin
        if (sts.div_done) begin
          cmd.cap3   = 1'b1;
          state_next = S_DIV5;
        end
      end
      S_DIV5: begin
        cmd.div_start = 1'b1;
        cmd.div_sel5  = 1'b1;
        state_next    = S_WAIT5;
      end
      S_WAIT5: begin
        cmd.div_sel5 = 1'b1;
        if (sts.div_done) begin
          cmd.cap5   = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.push_end = (job == JOB_END);
          case (job)
            JOB_NORM: begin
              if (fin) begin
                job_next   = JOB_MID;
                state_next = S_SUM;
              end else begin
                state_next = S_IDLE;
              end
            end
            JOB_MID: begin
              job_next   = JOB_END;
              state_next = S_SUM;
            end
            default: begin
              bins_seen_next = '0;
              fin_next       = 1'b0;
              state_next     = S_IDLE;
            end
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bins_seen <= '0;
      fin       <= 1'b0;
      job       <= JOB_END;
    end else begin
      state     <= state_next;
      bins_seen <= bins_seen_next;
      fin       <= fin_next;
      job       <= job_next;
    end
  end

endmodule
